// ===== rtl/sb62_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package sb62_pkg;

    // Alphabet: symbol k stands for digit value k, first symbol in the top byte
    localparam int SYM_COUNT = 62;
    localparam logic [8*SYM_COUNT-1:0] ALPHABET =
        "mfS4ODl7ejMkRJsP81ahITHygW9wLvKn2QFqGr6iAYEuxBZ0dct3b5NXpCUzoV";

    // A 63-bit value never needs more than 11 base-62 digits
    localparam int MAX_DIGITS = 11;

    // Chunked long division: 16-bit chunks, reciprocal of 62 scaled by 2^28
    localparam int CHUNK_W   = 16;
    localparam int NCHUNKS   = 4;
    localparam int REM_W     = 6;
    localparam int DIVX_W    = CHUNK_W + REM_W;
    localparam int DIV_SHIFT = 28;
    localparam logic [22:0] DIV_MULT = 23'd4329605;

    typedef enum logic [1:0] {
        ERR_NONE = 2'd0,
        ERR_CHAR = 2'd1,
        ERR_OVF  = 2'd2
    } err_t;

    typedef struct packed {
        logic        req_type;
        logic [62:0] number_in;
        logic [7:0]  char_in;
        logic        char_last;
    } req_t;

    typedef struct packed {
        logic [7:0]  char_out;
        logic [62:0] value_out;
        logic        is_decode_result;
        logic [1:0]  error_code;
        logic        last_out;
    } rsp_t;

    // Decode accumulator control
    typedef struct packed {
        logic fold;
        logic clear;
    } dec_ctrl_t;

    // Digit value to character
    function automatic logic [7:0] sym_of(input logic [5:0] d);
        logic [7:0] c;
        c = 8'd0;
        for (int k = 0; k < SYM_COUNT; k++) begin
            if (d == 6'(k)) begin
                c = ALPHABET[8*(SYM_COUNT-1-k) +: 8];
            end
        end
        return c;
    endfunction

    // Character to digit value; bit 6 flags a known symbol
    function automatic logic [6:0] digit_of(input logic [7:0] c);
        logic [6:0] r;
        r = 7'd0;
        for (int k = 0; k < SYM_COUNT; k++) begin
            if (c == ALPHABET[8*(SYM_COUNT-1-k) +: 8]) begin
                r = {1'b1, 6'(k)};
            end
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/sb62_divstep.sv =====
`timescale 1ns / 1ps
`default_nettype none

// One long-division step: {remainder, chunk} / 62
module sb62_divstep (
    input  wire logic [sb62_pkg::DIVX_W-1:0]  x,
    output logic      [sb62_pkg::CHUNK_W-1:0] q,
    output logic      [sb62_pkg::REM_W-1:0]   r
);
    import sb62_pkg::*;

    logic [DIVX_W+22:0] prod;
    logic [DIVX_W-1:0]  q62;
    logic [DIVX_W-1:0]  diff;

    // Reciprocal multiply, exact for x < 62 * 2^16
    assign prod = {23'd0, x} * {{DIVX_W{1'b0}}, DIV_MULT};
    assign q    = prod[DIV_SHIFT +: CHUNK_W];

    // Remainder: x - q*64 + q*2
    assign q62  = {q, 6'd0} - {5'd0, q, 1'b0};
    assign diff = x - q62;
    assign r    = diff[REM_W-1:0];

endmodule

`default_nettype wire

// ===== rtl/sb62_decacc.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Decode accumulator: value = value*62 + digit, sticky error
module sb62_decacc (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire sb62_pkg::dec_ctrl_t ctrl,
    input  wire logic [7:0]          char_in,
    output logic      [62:0]         acc,
    output sb62_pkg::err_t           err
);
    import sb62_pkg::*;

    logic [62:0] acc_reg, acc_next;
    err_t        err_reg, err_next;
    logic [6:0]  dig;
    logic [69:0] sum;

    assign dig = digit_of(char_in);
    assign sum = {1'b0, acc_reg, 6'd0} - {6'd0, acc_reg, 1'b0} + {63'd0, 1'b0, dig[5:0]};

    // Clear wins; otherwise fold one character unless an error is already latched
    always_comb
    begin
        acc_next = acc_reg;
        err_next = err_reg;
        if (ctrl.clear)
        begin
            acc_next = '0;
            err_next = ERR_NONE;
        end
        else if (ctrl.fold && err_reg == ERR_NONE)
        begin
            if (!dig[6])
            begin
                err_next = ERR_CHAR;
            end
            else if (sum[69:63] != 7'd0)
            begin
                err_next = ERR_OVF;
            end
            else
            begin
                acc_next = sum[62:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= '0;
            err_reg <= ERR_NONE;
        end
        else
        begin
            acc_reg <= acc_next;
            err_reg <= err_next;
        end
    end

    assign acc = acc_reg;
    assign err = err_reg;

endmodule

`default_nettype wire

// ===== rtl/shuffled_base62_codec_top.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Shuffled base-62 codec.
// Input channel req (valid/stall): one transaction is an encode request
// (req_type 0, number_in) or one decode character (req_type 1, char_in,
// char_last). Output channel rsp (valid/stall): one transaction per encoded
// character, most significant first, last_out on the final one; one decode
// result carrying value_out and error_code per string, on its last character.
// Encode: a single shared divide-by-62 step unit works through the 63-bit
// number in four 16-bit chunks, one digit per pass over the chunks; then one
// character leaves per cycle while rsp is not stalled.
// Decode: a character is folded in the cycle it is accepted; the final one
// moves the sequencer to ST_DOUT, which registers the result for output.
// req_stall is high whenever a request is in work, so one request at a time.
// When rsp is stalled the output register holds; ST_EMIT and ST_DOUT wait.
// Reset clears the sequencer, the output valid flag and the decode state.
module shuffled_base62_codec_top (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           req_valid,
    output logic                req_stall,
    input  wire sb62_pkg::req_t req,
    output logic                rsp_valid,
    input  wire logic           rsp_stall,
    output sb62_pkg::rsp_t      rsp
);
    import sb62_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_DIV  = 4'b0010,
        ST_EMIT = 4'b0100,
        ST_DOUT = 4'b1000
    } state_t;

    state_t                           state_reg, state_next;
    logic [NCHUNKS-1:0][CHUNK_W-1:0]  num_reg, num_next;
    logic [REM_W-1:0]                 rem_reg, rem_next;
    logic [1:0]                       idx_reg, idx_next;
    logic [3:0]                       cnt_reg, cnt_next;
    logic [3:0]                       eidx_reg, eidx_next;
    logic [5:0]                       digits_reg [MAX_DIGITS];
    rsp_t                             rsp_reg, rsp_next;
    logic                             rsp_valid_reg, rsp_valid_next;

    logic                             accept;
    logic                             slot_free;
    logic                             digit_we;
    logic [CHUNK_W-1:0]               div_q;
    logic [REM_W-1:0]                 div_r;
    logic                             quot_zero;
    dec_ctrl_t                        dec_ctrl;
    logic [62:0]                      dec_acc;
    err_t                             dec_err;

    assign accept    = req_valid && !req_stall;
    assign req_stall = (state_reg != ST_IDLE);
    assign slot_free = !rsp_valid_reg || !rsp_stall;

    // Shared division step
    sb62_divstep u_div (
        .x ({rem_reg, num_reg[idx_reg]}),
        .q (div_q),
        .r (div_r)
    );

    // Decode state
    assign dec_ctrl.fold  = accept && req.req_type;
    assign dec_ctrl.clear = (state_reg == ST_DOUT) && slot_free;

    sb62_decacc u_dec (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (dec_ctrl),
        .char_in (req.char_in),
        .acc     (dec_acc),
        .err     (dec_err)
    );

    // Whole quotient zero once the low chunk is done
    assign quot_zero = (num_reg[3] == '0) && (num_reg[2] == '0) &&
                       (num_reg[1] == '0) && (div_q == '0);

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        num_next       = num_reg;
        rem_next       = rem_reg;
        idx_next       = idx_reg;
        cnt_next       = cnt_reg;
        eidx_next      = eidx_reg;
        digit_we       = 1'b0;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg;
        if (slot_free)
        begin
            rsp_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (!req.req_type)
                    begin
                        num_next   = {1'b0, req.number_in};
                        rem_next   = '0;
                        idx_next   = 2'(NCHUNKS - 1);
                        cnt_next   = '0;
                        state_next = ST_DIV;
                    end
                    else if (req.char_last)
                    begin
                        state_next = ST_DOUT;
                    end
                end
            end

            ST_DIV:
            begin
                num_next[idx_reg] = div_q;
                rem_next          = div_r;
                if (idx_reg == 2'd0)
                begin
                    digit_we = 1'b1;
                    cnt_next = cnt_reg + 4'd1;
                    if (quot_zero || cnt_next == 4'(MAX_DIGITS))
                    begin
                        eidx_next  = cnt_reg;
                        state_next = ST_EMIT;
                    end
                    else
                    begin
                        idx_next = 2'(NCHUNKS - 1);
                        rem_next = '0;
                    end
                end
                else
                begin
                    idx_next = idx_reg - 2'd1;
                end
            end

            ST_EMIT:
            begin
                if (slot_free)
                begin
                    rsp_valid_next            = 1'b1;
                    rsp_next.char_out         = sym_of(digits_reg[eidx_reg]);
                    rsp_next.value_out        = '0;
                    rsp_next.is_decode_result = 1'b0;
                    rsp_next.error_code       = ERR_NONE;
                    rsp_next.last_out         = (eidx_reg == 4'd0);
                    if (eidx_reg == 4'd0)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        eidx_next = eidx_reg - 4'd1;
                    end
                end
            end

            ST_DOUT:
            begin
                if (slot_free)
                begin
                    rsp_valid_next            = 1'b1;
                    rsp_next.char_out         = 8'd0;
                    rsp_next.value_out        = (dec_err == ERR_NONE) ? dec_acc : '0;
                    rsp_next.is_decode_result = 1'b1;
                    rsp_next.error_code       = dec_err;
                    rsp_next.last_out         = 1'b1;
                    state_next                = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            idx_reg       <= '0;
            cnt_reg       <= '0;
            eidx_reg      <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            cnt_reg       <= cnt_next;
            eidx_reg      <= eidx_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        rem_reg <= rem_next;
        rsp_reg <= rsp_next;
        if (digit_we)
        begin
            digits_reg[cnt_reg] <= div_r;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // Checks
    a_err_zero_value: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp.error_code == ERR_NONE || rsp.value_out == '0))
        else $error("decode result with error carries a value");

    a_enc_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp.is_decode_result) |->
        (rsp.error_code == ERR_NONE && rsp.value_out == '0))
        else $error("encode result with decode fields set");

    a_div_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) |-> (cnt_reg < 4'(MAX_DIGITS)))
        else $error("digit count past limit");

    a_emit_index: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT) |-> (eidx_reg < cnt_reg))
        else $error("emit index beyond stored digits");

endmodule

`default_nettype wire

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps

module tb;
    import sb62_pkg::*;

    localparam logic [62:0] MAX63      = 63'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [62:0] P62_10     = 63'd839299365868340224;
    localparam int          RAND_ITEMS = 120;
    localparam int          DRAIN      = 80;
    localparam int          CYCLE_CAP  = 250000;
    localparam int          HOLD_LEN   = 300;
    localparam int          HOLD_AT    = 60;

    typedef struct packed {
        req_t       item;
        logic [2:0] gap;
    } pend_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic req_valid = 1'b0;
    logic req_stall;
    req_t req       = '0;
    logic rsp_valid;
    logic rsp_stall = 1'b0;
    rsp_t rsp;

    // pending transactions and expected results
    pend_t pend_q[$];
    rsp_t  want_q[$];

    // predictor copy of the decode state
    logic [62:0] acc_shadow = '0;
    err_t        err_shadow = ERR_NONE;

    logic req_took  = 1'b0;
    logic rsp_took  = 1'b0;
    int   req_gap   = 0;
    int   rsp_wait  = 0;
    int   hold_cnt  = 0;
    logic hold_done = 1'b0;
    logic fill_quiet = 1'b0;

    int req_count   = 0;
    int rsp_count   = 0;
    int mismatches  = 0;
    int cycles      = 0;
    int enc_items   = 0;
    int dec_strings = 0;
    int err_strings = 0;
    int queued      = 0;

    shuffled_base62_codec_top u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    always #5 clk = ~clk;

    // digit value -> alphabet character
    function automatic logic [7:0] sym_char(input int d);
        return ALPHABET[8*(SYM_COUNT-1-d) +: 8];
    endfunction

    // alphabet character -> digit value, -1 if not a symbol
    function automatic int sym_index(input logic [7:0] c);
        int idx;
        idx = -1;
        for (int k = 0; k < SYM_COUNT; k++)
        begin
            if (ALPHABET[8*(SYM_COUNT-1-k) +: 8] == c)
            begin
                idx = k;
            end
        end
        return idx;
    endfunction

    function automatic logic [62:0] rand63();
        logic [63:0] v;
        v = {$urandom, $urandom};
        return v[62:0];
    endfunction

    // random value with a random bit length, so short and long strings both occur
    function automatic logic [62:0] rand_sized();
        return rand63() >> $urandom_range(0, 62);
    endfunction

    // non-alphanumeric byte
    function automatic logic [7:0] bad_char();
        logic [7:0] c;
        c = 8'($urandom_range(0, 255));
        while (sym_index(c) >= 0)
        begin
            c = 8'($urandom_range(0, 255));
        end
        return c;
    endfunction

    // Expected results of one accepted transaction
    task automatic predict_codec(input req_t r);
        logic [63:0] n;
        logic [63:0] lim;
        int          digs[MAX_DIGITS];
        int          cnt;
        int          d;
        rsp_t        e;
        if (r.req_type == 1'b0)
        begin
            n   = {1'b0, r.number_in};
            cnt = 0;
            do
            begin
                digs[cnt] = int'(n % 64'd62);
                n = n / 64'd62;
                cnt++;
            end
            while (n != 0 && cnt < MAX_DIGITS);
            for (int i = 0; i < cnt; i++)
            begin
                e          = '0;
                e.char_out = sym_char(digs[cnt-1-i]);
                e.last_out = (i == cnt - 1);
                want_q.push_back(e);
            end
        end
        else
        begin
            // first error of a string sticks until its last character
            if (err_shadow == ERR_NONE)
            begin
                d = sym_index(r.char_in);
                if (d < 0)
                begin
                    err_shadow = ERR_CHAR;
                end
                else
                begin
                    lim = ({1'b0, MAX63} - 64'(d)) / 64'd62;
                    if ({1'b0, acc_shadow} > lim)
                    begin
                        err_shadow = ERR_OVF;
                    end
                    else
                    begin
                        acc_shadow = 63'(acc_shadow * 63'd62 + 63'(d));
                    end
                end
            end
            if (r.char_last)
            begin
                e                  = '0;
                e.value_out        = (err_shadow == ERR_NONE) ? acc_shadow : '0;
                e.is_decode_result = 1'b1;
                e.error_code       = err_shadow;
                e.last_out         = 1'b1;
                want_q.push_back(e);
                if (err_shadow != ERR_NONE)
                begin
                    err_strings++;
                end
                dec_strings++;
                acc_shadow = '0;
                err_shadow = ERR_NONE;
            end
        end
    endtask

    task automatic report_mismatch(input string what, input rsp_t e, input rsp_t a);
        mismatches++;
        if (mismatches <= 10)
        begin
            $display("MISMATCH %0s at cycle %0d", what, cycles);
            $display("  expected char=%h value=%h dec=%b err=%0d last=%b",
                     e.char_out, e.value_out, e.is_decode_result, e.error_code, e.last_out);
            $display("  actual   char=%h value=%h dec=%b err=%0d last=%b",
                     a.char_out, a.value_out, a.is_decode_result, a.error_code, a.last_out);
        end
    endtask

    // Queue one transaction; unused fields carry random junk
    task automatic push_req(input logic rtype, input logic [62:0] num,
                            input logic [7:0] ch, input logic last);
        pend_t p;
        p.item.req_type  = rtype;
        p.item.number_in = rtype ? rand63() : num;
        p.item.char_in   = rtype ? ch : 8'($urandom_range(0, 255));
        p.item.char_last = rtype ? last : 1'($urandom_range(0, 1));
        p.gap            = fill_quiet ? 3'd0 : 3'($urandom_range(0, 6));
        pend_q.push_back(p);
        if (!rtype)
        begin
            enc_items++;
        end
        queued++;
    endtask

    // Queue the decode string of v; a bad character replaces position bad_at (-1: none)
    task automatic push_string(input logic [62:0] v, input int bad_at);
        logic [63:0] n;
        int          digs[MAX_DIGITS];
        int          cnt;
        logic [7:0]  c;
        n   = {1'b0, v};
        cnt = 0;
        do
        begin
            digs[cnt] = int'(n % 64'd62);
            n = n / 64'd62;
            cnt++;
        end
        while (n != 0 && cnt < MAX_DIGITS);
        for (int i = 0; i < cnt; i++)
        begin
            c = (i == bad_at) ? bad_char() : sym_char(digs[cnt-1-i]);
            push_req(1'b1, '0, c, i == cnt - 1);
        end
    endtask

    // Request driver
    always @(negedge clk)
    begin : req_driver
        if (rst_n)
        begin
            if (!(req_valid && !req_took))
            begin
                if (req_gap != 0)
                begin
                    req_valid <= 1'b0;
                    req_gap   <= req_gap - 1;
                end
                else if (pend_q.size() != 0)
                begin
                    req       <= pend_q[0].item;
                    req_gap   <= int'(pend_q[0].gap);
                    req_valid <= 1'b1;
                    pend_q.pop_front();
                end
                else
                begin
                    req_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver stall: random wait per result, plus the long hold-off
    always @(negedge clk)
    begin : rsp_driver
        int  w;
        logic quiet;
        quiet = ((rsp_count / 50) % 3) == 1;
        w = rsp_wait;
        if (rsp_took)
        begin
            w = quiet ? 0 : $urandom_range(0, 6);
        end
        else if (w != 0)
        begin
            w = w - 1;
        end
        rsp_wait  <= w;
        rsp_stall <= (hold_cnt != 0) || (w != 0);
    end

    // Long receiver hold-off once traffic is flowing
    always @(negedge clk)
    begin : hold_off
        if (!hold_done && req_count >= HOLD_AT)
        begin
            hold_cnt  <= HOLD_LEN;
            hold_done <= 1'b1;
        end
        else if (hold_cnt != 0)
        begin
            hold_cnt <= hold_cnt - 1;
        end
    end

    // Monitor: predict on accepted requests, check accepted results
    always @(posedge clk)
    begin : monitor
        rsp_t e;
        req_took <= req_valid && !req_stall;
        rsp_took <= rsp_valid && !rsp_stall;
        if (rst_n)
        begin
            if (req_valid && !req_stall)
            begin
                predict_codec(req);
                req_count <= req_count + 1;
            end
            if (rsp_valid && !rsp_stall)
            begin
                rsp_count <= rsp_count + 1;
                if (want_q.size() == 0)
                begin
                    report_mismatch("unexpected result", '0, rsp);
                end
                else
                begin
                    e = want_q.pop_front();
                    if (rsp.char_out !== e.char_out || rsp.value_out !== e.value_out ||
                        rsp.is_decode_result !== e.is_decode_result ||
                        rsp.error_code !== e.error_code || rsp.last_out !== e.last_out)
                    begin
                        report_mismatch("result field", e, rsp);
                    end
                end
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin : watchdog
        cycles <= cycles + 1;
        if (cycles > CYCLE_CAP)
        begin
            $display("Timeout after %0d cycles", cycles);
            $display("Test completed with failures");
            $finish;
        end
    end

    // Stimulus and end of run
    initial
    begin : stimulus
        int kind;
        int start;
        int n;
        logic [62:0] v;

        // directed: encode extremes and digit-count boundaries
        push_req(1'b0, 63'd0, 8'd0, 1'b0);
        push_req(1'b0, 63'd61, 8'd0, 1'b0);
        push_req(1'b0, 63'd62, 8'd0, 1'b0);
        push_req(1'b0, P62_10, 8'd0, 1'b0);
        push_req(1'b0, MAX63, 8'd0, 1'b0);
        // single top symbol
        push_req(1'b1, '0, "V", 1'b1);
        // encode in the middle of a decode string leaves the accumulator alone
        push_req(1'b1, '0, "f", 1'b0);
        push_req(1'b0, 63'd5, 8'd0, 1'b0);
        push_req(1'b1, '0, "f", 1'b1);
        // unknown character sticks through the rest of the string
        push_req(1'b1, '0, "#", 1'b0);
        push_req(1'b1, '0, "V", 1'b0);
        push_req(1'b1, '0, "f", 1'b1);
        // unknown character on the last one
        push_req(1'b1, '0, "f", 1'b0);
        push_req(1'b1, '0, 8'hFF, 1'b1);
        push_req(1'b1, '0, 8'h00, 1'b1);
        // overflow on the eleventh symbol, then a bad character that must not override it
        for (int i = 0; i < 11; i++)
        begin
            push_req(1'b1, '0, "V", 1'b0);
        end
        push_req(1'b1, '0, "#", 1'b1);

        // random: mostly well-formed strings and encodes, some broken input
        start = queued;
        push_string(MAX63, -1);
        push_string(63'd0, -1);
        while (queued - start < RAND_ITEMS)
        begin
            fill_quiet = (((queued - start) / 40) % 3) == 1;
            kind = $urandom_range(0, 9);
            if (kind <= 3)
            begin
                v = (kind == 0) ? rand63() : rand_sized();
                push_req(1'b0, v, 8'd0, 1'b0);
            end
            else if (kind <= 7)
            begin
                push_string(rand_sized(), -1);
            end
            else if (kind == 8)
            begin
                push_string(rand_sized(), $urandom_range(0, 10));
            end
            else
            begin
                // random symbols, one to twelve of them, so some strings overflow
                n = $urandom_range(1, 12);
                for (int i = 0; i < n; i++)
                begin
                    push_req(1'b1, '0, sym_char($urandom_range(0, SYM_COUNT - 1)), i == n - 1);
                end
            end
        end
        fill_quiet = 1'b0;
        // close any open string so nothing is left hanging
        push_req(1'b1, '0, "m", 1'b1);

        repeat (8) @(negedge clk);
        rst_n = 1'b1;

        while (pend_q.size() != 0 || req_valid)
        begin
            @(posedge clk);
        end
        while (want_q.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN) @(posedge clk);

        $display("Ran %0d requests (%0d encodes, %0d decode strings, %0d with errors)",
                 req_count, enc_items, dec_strings, err_strings);
        $display("Checked %0d results, %0d mismatches, receiver hold-off of %0d cycles",
                 rsp_count, mismatches, HOLD_LEN);
        if (mismatches == 0 && want_q.size() == 0)
        begin
            $display("Test completed successfully");
        end
        else
        begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
